// File: hdl/gyro_tilt_gesture_detector_defines.svh
// assertion macros for the gyro tilt gesture detector
// used by the top level, needs a clock named clock and a reset named reset
`ifndef GYRO_TILT_GESTURE_DETECTOR_DEFINES_SVH
`define GYRO_TILT_GESTURE_DETECTOR_DEFINES_SVH

// property checked on every clock edge outside reset
`define GTG_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define GTG_NEVER(label, cond, msg) \
   `GTG_ASSERT(label, !(cond), msg)

`endif

// File: hdl/gtg_pkg.sv
// shared types, codes and constants of the gyro tilt gesture detector
// no dependencies
package gtg_pkg;

   localparam int TIME_BITS = 32;
   localparam int NOW_BITS  = 32;
   localparam int RATE_BITS = 16;
   localparam int THR_BITS  = 15;
   localparam int MS_BITS   = 16;
   localparam int AXIS_BITS = RATE_BITS + 1;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 32;

   typedef logic [TIME_BITS-1:0] time_type;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_SENSOR_PRESENT   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_TIME_MS    = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TRIGGER_RATE     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NEUTRAL_RATE     = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HOLDOFF_MS       = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SAMPLE_PERIOD_MS = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WAKE_SETTLE_MS   = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SLEEP_SETTLE_MS  = 3'd7;

   // register reset values
   localparam logic [THR_BITS-1:0] TRIGGER_RATE_RST     = 15'd6400;
   localparam logic [THR_BITS-1:0] NEUTRAL_RATE_RST     = 15'd1280;
   localparam logic [MS_BITS-1:0]  HOLDOFF_MS_RST       = 16'd500;
   localparam logic [MS_BITS-1:0]  SAMPLE_PERIOD_MS_RST = 16'd20;
   localparam logic [MS_BITS-1:0]  WAKE_SETTLE_MS_RST   = 16'd100;
   localparam logic [MS_BITS-1:0]  SLEEP_SETTLE_MS_RST  = 16'd100;

   // mode codes
   localparam logic [1:0] MODE_OFF      = 2'd0;
   localparam logic [1:0] MODE_NORMAL   = 2'd1;
   localparam logic [1:0] MODE_INVERTED = 2'd2;

   // orientation codes
   localparam logic [1:0] ORIENT_PORTRAIT  = 2'd0;
   localparam logic [1:0] ORIENT_INVERTED  = 2'd1;
   localparam logic [1:0] ORIENT_LAND_CW   = 2'd2;
   localparam logic [1:0] ORIENT_LAND_CCW  = 2'd3;

   typedef struct packed {
      logic                sensor_present;
      logic [NOW_BITS-1:0] start_time_ms;
      logic [THR_BITS-1:0] trigger_rate;
      logic [THR_BITS-1:0] neutral_rate;
      logic [MS_BITS-1:0]  holdoff_ms;
      logic [MS_BITS-1:0]  sample_period_ms;
      logic [MS_BITS-1:0]  wake_settle_ms;
      logic [MS_BITS-1:0]  sleep_settle_ms;
   } cfg_type;

   typedef struct packed {
      logic                        awake;
      logic                        in_tilt;
      time_type                    wake_stamp;
      time_type                    last_poll_stamp;
      time_type                    last_event_stamp;
      logic                        forward_flag;
      logic                        back_flag;
      logic                        activity_flag;
   } state_type;

   typedef struct packed {
      logic [NOW_BITS-1:0]         now_ms;
      logic [1:0]                  mode;
      logic [1:0]                  orientation;
      logic                        in_reader;
      logic                        bus_ok;
      logic signed [RATE_BITS-1:0] rate_x;
      logic signed [RATE_BITS-1:0] rate_y;
      logic                        clear_events;
   } req_type;

   typedef struct packed {
      logic forward_pending;
      logic back_pending;
      logic activity_pending;
      logic sensor_awake;
      logic tilt_active;
      logic sample_taken;
   } rsp_type;

endpackage

// File: hdl/gtg_cfg_regs.sv
// configuration register file of the gyro tilt gesture detector
// depends on gtg_pkg
module gtg_cfg_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [gtg_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [gtg_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output gtg_pkg::cfg_type                    cfg
);

   gtg_pkg::cfg_type cfg_ff;
   gtg_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            gtg_pkg::CSR_SENSOR_PRESENT:   cfg_in.sensor_present = csr_wdata[0];
            gtg_pkg::CSR_START_TIME_MS:
               cfg_in.start_time_ms = csr_wdata[gtg_pkg::NOW_BITS-1:0];
            gtg_pkg::CSR_TRIGGER_RATE:
               cfg_in.trigger_rate = csr_wdata[gtg_pkg::THR_BITS-1:0];
            gtg_pkg::CSR_NEUTRAL_RATE:
               cfg_in.neutral_rate = csr_wdata[gtg_pkg::THR_BITS-1:0];
            gtg_pkg::CSR_HOLDOFF_MS:
               cfg_in.holdoff_ms = csr_wdata[gtg_pkg::MS_BITS-1:0];
            gtg_pkg::CSR_SAMPLE_PERIOD_MS:
               cfg_in.sample_period_ms = csr_wdata[gtg_pkg::MS_BITS-1:0];
            gtg_pkg::CSR_WAKE_SETTLE_MS:
               cfg_in.wake_settle_ms = csr_wdata[gtg_pkg::MS_BITS-1:0];
            gtg_pkg::CSR_SLEEP_SETTLE_MS:
               cfg_in.sleep_settle_ms = csr_wdata[gtg_pkg::MS_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sensor_present   <= 1'b0;
         cfg_ff.start_time_ms    <= '0;
         cfg_ff.trigger_rate     <= gtg_pkg::TRIGGER_RATE_RST;
         cfg_ff.neutral_rate     <= gtg_pkg::NEUTRAL_RATE_RST;
         cfg_ff.holdoff_ms       <= gtg_pkg::HOLDOFF_MS_RST;
         cfg_ff.sample_period_ms <= gtg_pkg::SAMPLE_PERIOD_MS_RST;
         cfg_ff.wake_settle_ms   <= gtg_pkg::WAKE_SETTLE_MS_RST;
         cfg_ff.sleep_settle_ms  <= gtg_pkg::SLEEP_SETTLE_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hdl/gtg_step.sv
// next-state and response logic for one update request
// depends on gtg_pkg
module gtg_step (
   input  gtg_pkg::cfg_type   cfg,
   input  gtg_pkg::state_type st,
   input  gtg_pkg::req_type   req,
   output gtg_pkg::state_type st_next,
   output gtg_pkg::rsp_type   rsp
);

   gtg_pkg::time_type                     now_t;
   gtg_pkg::time_type                     el_start;
   gtg_pkg::time_type                     el_wake;
   gtg_pkg::time_type                     el_poll;
   gtg_pkg::time_type                     el_event;
   logic                                  inv;
   logic                                  active;
   logic                                  sample;
   logic                                  negate;
   logic signed [gtg_pkg::AXIS_BITS-1:0]  raw;
   logic signed [gtg_pkg::AXIS_BITS-1:0]  axis;
   logic signed [gtg_pkg::AXIS_BITS-1:0]  mag;
   logic signed [gtg_pkg::AXIS_BITS-1:0]  trig;
   logic signed [gtg_pkg::AXIS_BITS-1:0]  neutral;

   always_comb begin
      now_t    = gtg_pkg::time_type'(req.now_ms);
      el_start = now_t - gtg_pkg::time_type'(cfg.start_time_ms);
      el_wake  = now_t - st.wake_stamp;
      el_poll  = now_t - st.last_poll_stamp;
      el_event = now_t - st.last_event_stamp;
      inv      = (req.mode == gtg_pkg::MODE_INVERTED);
      active   = req.in_reader && (req.mode != gtg_pkg::MODE_OFF);

      // axis selection and sign
      case (req.orientation)
         gtg_pkg::ORIENT_PORTRAIT: negate = inv;
         gtg_pkg::ORIENT_INVERTED: negate = !inv;
         gtg_pkg::ORIENT_LAND_CW:  negate = !inv;
         default:                  negate = inv;
      endcase
      raw = req.orientation[1] ? gtg_pkg::AXIS_BITS'(req.rate_y)
                               : gtg_pkg::AXIS_BITS'(req.rate_x);
      axis    = negate ? -raw : raw;
      mag     = axis[gtg_pkg::AXIS_BITS-1] ? -axis : axis;
      trig    = signed'({2'b00, cfg.trigger_rate});
      neutral = signed'({2'b00, cfg.neutral_rate});

      st_next = st;
      sample  = 1'b0;

      if (cfg.sensor_present) begin
         if (!active) begin
            if (st.awake && req.bus_ok &&
                el_wake >= gtg_pkg::time_type'(cfg.sleep_settle_ms)) begin
               st_next.forward_flag  = 1'b0;
               st_next.back_flag     = 1'b0;
               st_next.activity_flag = 1'b0;
               st_next.in_tilt       = 1'b0;
               st_next.awake         = 1'b0;
            end
         end else if (!st.awake) begin
            if (req.bus_ok &&
                el_start >= gtg_pkg::time_type'(cfg.sleep_settle_ms)) begin
               st_next.last_poll_stamp  = now_t;
               st_next.last_event_stamp = now_t;
               st_next.wake_stamp       = now_t;
               st_next.awake            = 1'b1;
            end
         end else if (el_wake >= gtg_pkg::time_type'(cfg.wake_settle_ms) &&
                      el_poll >= gtg_pkg::time_type'(cfg.sample_period_ms)) begin
            st_next.last_poll_stamp = now_t;
            if (req.bus_ok) begin
               sample = 1'b1;
               if (st.in_tilt) begin
                  if (mag < neutral) begin
                     st_next.in_tilt = 1'b0;
                  end
               end else if (el_event >= gtg_pkg::time_type'(cfg.holdoff_ms)) begin
                  if (axis > trig) begin
                     st_next.forward_flag     = 1'b1;
                     st_next.activity_flag    = 1'b1;
                     st_next.in_tilt          = 1'b1;
                     st_next.last_event_stamp = now_t;
                  end else if (axis < -trig) begin
                     st_next.back_flag        = 1'b1;
                     st_next.activity_flag    = 1'b1;
                     st_next.in_tilt          = 1'b1;
                     st_next.last_event_stamp = now_t;
                  end
               end
            end
         end
      end

      rsp.forward_pending  = st_next.forward_flag;
      rsp.back_pending     = st_next.back_flag;
      rsp.activity_pending = st_next.activity_flag;
      rsp.sensor_awake     = st_next.awake;
      rsp.tilt_active      = st_next.in_tilt;
      rsp.sample_taken     = sample;

      // flags clear after they are reported
      if (cfg.sensor_present && req.clear_events) begin
         st_next.forward_flag  = 1'b0;
         st_next.back_flag     = 1'b0;
         st_next.activity_flag = 1'b0;
      end
   end

endmodule

// File: hdl/gyro_tilt_gesture_detector.sv
// Gyro tilt gesture detector, top level.
// Depends on gtg_pkg, gtg_cfg_regs, gtg_step and the assertion macro header.
//
// Usage:
//   Each request on the req_ channel is one update call: time stamp, mode,
//   orientation, reader and bus status, raw X/Y rates and a clear flag.
//   Each request gives exactly one response on the rsp_ channel with the
//   pending tilt events, the awake and in-tilt status and a sample flag.
//   Configuration is written through csr_wen/csr_index/csr_wdata, one
//   register per cycle, while no request is in flight.
// Timing:
//   A request is captured in an input register; the combinational update
//   logic then moves the detector state and loads the response register
//   when it is empty or being taken; rsp_valid rises as it is loaded.
//   Throughput is one request per cycle while rsp_ready stays high.
// Reset:
//   Sensor asleep, no tilt, all stamps and flags zero, registers at their
//   defaults (sensor marked absent). Both channels come up empty.
// Stall:
//   A held response keeps its register; one more request may wait in the
//   input register, after which req_ready drops until the response is taken.
`include "gyro_tilt_gesture_detector_defines.svh"

module gyro_tilt_gesture_detector (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [gtg_pkg::NOW_BITS-1:0]          req_now_ms,
   input  logic [1:0]                            req_mode,
   input  logic [1:0]                            req_orientation,
   input  logic                                  req_in_reader,
   input  logic                                  req_bus_ok,
   input  logic signed [gtg_pkg::RATE_BITS-1:0]  req_rate_x,
   input  logic signed [gtg_pkg::RATE_BITS-1:0]  req_rate_y,
   input  logic                                  req_clear_events,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_forward_pending,
   output logic                                  rsp_back_pending,
   output logic                                  rsp_activity_pending,
   output logic                                  rsp_sensor_awake,
   output logic                                  rsp_tilt_active,
   output logic                                  rsp_sample_taken,
   input  logic                                  csr_wen,
   input  logic [gtg_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [gtg_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   gtg_pkg::cfg_type   cfg;
   gtg_pkg::req_type   req_ff;
   gtg_pkg::req_type   req_in;
   logic               req_valid_ff;
   logic               req_valid_in;
   gtg_pkg::state_type state_ff;
   gtg_pkg::state_type state_in;
   gtg_pkg::rsp_type   rsp_ff;
   gtg_pkg::rsp_type   rsp_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               advance;
   logic               req_take;

   gtg_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gtg_step u_step (
      .cfg     (cfg),
      .st      (state_ff),
      .req     (req_ff),
      .st_next (state_in),
      .rsp     (rsp_in)
   );

   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      req_in.now_ms       = req_now_ms;
      req_in.mode         = req_mode;
      req_in.orientation  = req_orientation;
      req_in.in_reader    = req_in_reader;
      req_in.bus_ok       = req_bus_ok;
      req_in.rate_x       = req_rate_x;
      req_in.rate_y       = req_rate_y;
      req_in.clear_events = req_clear_events;
      req_valid_in = req_take || (req_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
      if (req_take) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_forward_pending  = rsp_ff.forward_pending;
   assign rsp_back_pending     = rsp_ff.back_pending;
   assign rsp_activity_pending = rsp_ff.activity_pending;
   assign rsp_sensor_awake     = rsp_ff.sensor_awake;
   assign rsp_tilt_active      = rsp_ff.tilt_active;
   assign rsp_sample_taken     = rsp_ff.sample_taken;

   `GTG_NEVER(a_tilt_needs_awake, state_ff.in_tilt && !state_ff.awake, "in tilt while asleep")
   `GTG_NEVER(a_event_sets_activity, (state_ff.forward_flag || state_ff.back_flag) && !state_ff.activity_flag, "event flag without activity flag")
   `GTG_ASSERT(a_state_holds, (!advance |=> $stable(state_ff)), "state moved without a request")
   `GTG_ASSERT(a_rsp_from_request, ($rose(rsp_valid_ff) |-> $past(advance)), "response without a request")

endmodule
